@@ rtl/irf_pkg.sv @@
// ----------------------------------------------------------------------------
// irf_pkg: shared types and constants of the integer radix formatter
// Holds the status codes, ASCII constants and the digit character lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package irf_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_RADIX = 2'd2
    } t_status;

    // radix limits and the one radix that takes a prefix
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_HEX = 6'd16;

    // digit store geometry
    localparam int unsigned DIGIT_DEPTH = 64;
    localparam int unsigned DIGIT_W     = 6;

    // ascii codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // digit value to its ascii character, letters in the chosen case
    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d < 6'd10) begin
            return CH_ZERO + {2'b00, d};
        end else begin
            return base + {2'b00, d} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/irf_if.sv @@
// ----------------------------------------------------------------------------
// irf_if: request and result channels of the integer radix formatter
// Valid/ready channels; a request moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface irf_req_if;
    logic               valid;
    logic               ready;
    logic [63:0]        value;
    logic [5:0]         radix;
    logic [6:0]         min_width;
    logic signed [6:0]  min_digits;
    logic               zero_pad;
    logic               signed_value;
    logic               force_plus;
    logic               space_sign;
    logic               left_justify;
    logic               alt_prefix;
    logic               upper_case;
    logic               suppress_prefix;

    modport source (
        output valid, value, radix, min_width, min_digits, zero_pad, signed_value,
               force_plus, space_sign, left_justify, alt_prefix, upper_case,
               suppress_prefix,
        input  ready
    );
    modport sink (
        input  valid, value, radix, min_width, min_digits, zero_pad, signed_value,
               force_plus, space_sign, left_justify, alt_prefix, upper_case,
               suppress_prefix,
        output ready
    );
endinterface

interface irf_rsp_if;
    logic               valid;
    logic               ready;
    logic [7:0]         character;
    logic               last_char;
    irf_pkg::t_status   status;
    logic               truncated;
    logic [6:0]         total_length;

    modport source (
        output valid, character, last_char, status, truncated, total_length,
        input  ready
    );
    modport sink (
        input  valid, character, last_char, status, truncated, total_length,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/irf_ram.sv @@
// ----------------------------------------------------------------------------
// irf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module irf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/integer_radix_formatter_unit.sv @@
// ----------------------------------------------------------------------------
// integer_radix_formatter_unit: printf-style integer to text conversion
// Converts one 64-bit value per request into ASCII characters, one per result.
// ----------------------------------------------------------------------------
// One request is taken at a time; ready is high only while the unit is idle.
// The digits come from one shared restoring divider that produces one quotient
// bit per cycle, so each digit takes 64 divide steps and a check. The S_LEN,
// S_PAD and S_BND states then size the field, and each character passes a digit
// store read, then the output register load, which waits while the result side
// holds ready low. Bad radix and empty conversions give a single result.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_radix_formatter_unit #(
    parameter int unsigned MAX_CHARS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    irf_req_if.sink         i_req,
    irf_rsp_if.source       o_rsp
);

    import irf_pkg::*;

    localparam logic [6:0] MAX_LEN = 7'(MAX_CHARS);
    localparam int unsigned AW     = $clog2(DIGIT_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_LEN   = 9'b000001000,
        S_PAD   = 9'b000010000,
        S_BND   = 9'b000100000,
        S_RD    = 9'b001000000,
        S_LD    = 9'b010000000,
        S_ONE   = 9'b100000000
    } t_state;

    t_state      r_state, n_state;
    logic        r_o_valid, n_o_valid;

    // request fields held for the conversion
    logic [63:0] r_mag;
    logic [5:0]  r_radix;
    logic [6:0]  r_width;
    logic        r_md_given;
    logic [5:0]  r_md;
    logic        r_zpad;
    logic        r_left;
    logic        r_upper;
    logic        r_has_sign;
    logic [7:0]  r_sign_ch;
    logic        r_prefix;
    t_status     r_one_status;

    // divider and digit count
    logic [5:0]  r_rem;
    logic [5:0]  r_bit;
    logic [6:0]  r_nd;

    // field layout
    logic [6:0]  r_fixed;
    logic [6:0]  r_pad;
    logic [6:0]  r_len;
    logic [6:0]  r_b1, r_b2, r_b3, r_b4, r_b5;
    logic [6:0]  r_count;
    logic [6:0]  r_pos;

    // output register
    logic [7:0]  r_o_char;
    logic        r_o_last;
    t_status     r_o_status;
    logic        r_o_trunc;
    logic [6:0]  r_o_total;

    logic        w_req_fire;
    logic        w_out_free;
    logic        w_bad_radix;
    logic        w_neg;
    logic [6:0]  w_shift;
    logic        w_ge;
    logic [5:0]  n_rem;
    logic        w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [DIGIT_W-1:0] w_ram_wdata;
    logic [6:0]  w_rd_idx;
    logic [DIGIT_W-1:0] w_rd_digit;
    logic        w_last;
    logic [7:0]  w_char;
    logic [6:0]  w_prec;
    logic [6:0]  w_lead;
    logic [6:0]  w_tail;

    assign i_req.ready  = (r_state == S_IDLE);
    assign w_req_fire   = i_req.valid && i_req.ready;
    assign w_out_free   = !r_o_valid || o_rsp.ready;

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.character    = r_o_char;
    assign o_rsp.last_char    = r_o_last;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.truncated    = r_o_trunc;
    assign o_rsp.total_length = r_o_total;

    // request decode
    assign w_bad_radix = (i_req.radix < RADIX_MIN) || (i_req.radix > RADIX_MAX);
    assign w_neg       = i_req.signed_value && i_req.value[63];

    // one restoring divide step: remainder stays below the radix
    assign w_shift = {r_rem, r_mag[63]};
    assign w_ge    = (w_shift >= {1'b0, r_radix});
    assign n_rem   = w_ge ? 6'(w_shift - {1'b0, r_radix}) : w_shift[5:0];

    // digit store writes: divider remainders, or a lone zero digit
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_nd[AW-1:0];
        w_ram_wdata = n_rem;
        if (r_state == S_DIV && r_bit == 6'd0) begin
            w_ram_we = 1'b1;
        end else if (r_state == S_CHECK && r_mag == 64'd0 && r_nd == 7'd0
                     && !(r_md_given && r_md == 6'd0)) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = '0;
            w_ram_wdata = '0;
        end
    end

    // digits are stored least significant first, read back from the top
    assign w_rd_idx = r_b5 - 7'd1 - r_pos;

    irf_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_rd_idx[AW-1:0]),
        .o_rdata (w_rd_digit)
    );

    // effective digit count and padding placement
    assign w_prec = (r_md_given && {1'b0, r_md} > r_nd) ? {1'b0, r_md} : r_nd;
    assign w_lead = (!r_zpad && !r_left) ? r_pad : 7'd0;
    assign w_tail = r_left ? r_pad : 7'd0;

    // character at the current position
    assign w_last = (r_pos == r_count - 7'd1);
    always_comb begin
        if (r_pos < r_b1) begin
            w_char = CH_SPACE;
        end else if (r_pos < r_b2) begin
            w_char = r_sign_ch;
        end else if (r_pos < r_b3) begin
            w_char = (r_pos == r_b2) ? CH_ZERO : (r_upper ? CH_UPPER_X : CH_LOWER_X);
        end else if (r_pos < r_b4) begin
            w_char = CH_ZERO;
        end else if (r_pos < r_b5) begin
            w_char = digit_char(w_rd_digit, r_upper);
        end else begin
            w_char = CH_SPACE;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_o_valid = r_o_valid && !o_rsp.ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_fire) begin
                    n_state = w_bad_radix ? S_ONE : S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (r_mag == 64'd0) ? S_LEN : S_DIV;
            end
            S_DIV: begin
                if (r_bit == 6'd0) begin
                    n_state = S_CHECK;
                end
            end
            S_LEN: n_state = S_PAD;
            S_PAD: n_state = S_BND;
            S_BND: n_state = (r_len == 7'd0) ? S_ONE : S_RD;
            S_RD:  n_state = S_LD;
            S_LD: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_state   = w_last ? S_IDLE : S_RD;
                end
            end
            S_ONE: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_mag        <= w_neg ? (64'd0 - i_req.value) : i_req.value;
                r_radix      <= i_req.radix;
                r_width      <= i_req.min_width;
                r_md_given   <= !i_req.min_digits[6];
                r_md         <= i_req.min_digits[5:0];
                r_zpad       <= i_req.zero_pad && !i_req.left_justify;
                r_left       <= i_req.left_justify;
                r_upper      <= i_req.upper_case;
                r_has_sign   <= w_neg || (i_req.signed_value
                                          && (i_req.force_plus || i_req.space_sign));
                r_sign_ch    <= w_neg ? CH_MINUS : (i_req.force_plus ? CH_PLUS : CH_SPACE);
                r_prefix     <= i_req.alt_prefix && !i_req.suppress_prefix
                                && (i_req.radix == RADIX_HEX);
                r_nd         <= 7'd0;
                r_one_status <= ST_BAD_RADIX;
            end
            S_CHECK: begin
                r_rem <= 6'd0;
                r_bit <= 6'd63;
                if (w_ram_we) begin
                    r_nd <= 7'd1;
                end
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_mag <= {r_mag[62:0], w_ge};
                r_bit <= r_bit - 6'd1;
                if (r_bit == 6'd0) begin
                    r_nd <= r_nd + 7'd1;
                end
            end
            S_LEN: begin
                r_fixed <= w_prec + {6'd0, r_has_sign} + (r_prefix ? 7'd2 : 7'd0);
            end
            S_PAD: begin
                r_pad <= (r_width > r_fixed) ? (r_width - r_fixed) : 7'd0;
                r_len <= (r_width > r_fixed) ? r_width : r_fixed;
            end
            S_BND: begin
                r_b1         <= w_lead;
                r_b2         <= w_lead + {6'd0, r_has_sign};
                r_b3         <= w_lead + {6'd0, r_has_sign} + (r_prefix ? 7'd2 : 7'd0);
                r_b4         <= r_len - w_tail - r_nd;
                r_b5         <= r_len - w_tail;
                r_count      <= (r_len > MAX_LEN) ? MAX_LEN : r_len;
                r_pos        <= 7'd0;
                r_one_status <= ST_EMPTY;
            end
            S_RD: begin
            end
            S_LD: begin
                if (w_out_free) begin
                    r_o_char   <= w_char;
                    r_o_last   <= w_last;
                    r_o_status <= ST_OK;
                    r_o_trunc  <= w_last && (r_len > MAX_LEN);
                    r_o_total  <= w_last ? r_len : 7'd0;
                    r_pos      <= r_pos + 7'd1;
                end
            end
            S_ONE: begin
                if (w_out_free) begin
                    r_o_char   <= CH_NUL;
                    r_o_last   <= 1'b1;
                    r_o_status <= r_one_status;
                    r_o_trunc  <= 1'b0;
                    r_o_total  <= 7'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // digit count never passes the store depth
    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_nd <= 7'(DIGIT_DEPTH))
        else $error("digit count beyond store depth");

    // divider remainder always below the radix
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_radix)
        else $error("divider remainder not below radix");

    // a taken request starts either a conversion or a single status result
    a_req_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> (r_state == S_CHECK || r_state == S_ONE))
        else $error("request taken without starting work");

    // truncation flag agrees with the reported length on a final character
    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_last && r_o_status == ST_OK |->
            r_o_trunc == (r_o_total > MAX_LEN))
        else $error("truncated flag disagrees with total length");

    // characters are never emitted past the cut
    a_pos_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LD |-> r_pos < r_count)
        else $error("character position past the cut");

endmodule

`default_nettype wire
